// ===== sv/ctyr_pkg.sv =====
// Shared types, constants and tables for the coordinated-turn yaw rate block.
// Used by the CORDIC cell, the divider cell and the top level.
package ctyr_pkg;

    // CORDIC datapath width and step count.
    localparam int CW           = 27;
    localparam int CORDIC_STEPS = 20;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 27'sd10188014;
    localparam logic signed [27:0]   PI_Q24      = 28'sd52707179;
    localparam logic signed [27:0]   PI_HALF_Q24 = 28'sd26353589;

    // Roll thresholds in 2^-13 rad.
    localparam logic signed [15:0] INVERT_LIMIT = 16'sd12868;
    localparam logic signed [15:0] ROLL_CLAMP   = 16'sd11436;

    // Gravity in Q16 and Euler rate saturation.
    localparam logic [19:0] G_Q16     = 20'd642689;
    localparam logic [17:0] EULER_MAX = 18'd262143;

    // Configuration register indexes, floors and reset values.
    localparam logic REG_RATE_LIMIT   = 1'b0;
    localparam logic REG_MIN_AIRSPEED = 1'b1;

    localparam logic [14:0] RATE_LIMIT_LOW     = 15'd41;
    localparam logic [14:0] RATE_LIMIT_RESET   = 15'd3217;
    localparam logic [15:0] MIN_AIRSPEED_LOW   = 16'd256;
    localparam logic [15:0] MIN_AIRSPEED_RESET = 16'd2560;

    // Divider geometry: tangent divider and airspeed divider.
    localparam int DA_DW = 27;
    localparam int DA_NW = 28;
    localparam int DB_DW = 16;
    localparam int DB_NW = 20;

    // Data carried alongside the roll rotation.
    typedef struct packed {
        logic signed [15:0] prate;
        logic [15:0]        speed;
        logic               inv;
        logic               flip_r;
    } front_pay_t;

    // Data carried through the tangent divider.
    typedef struct packed {
        logic signed [CW-1:0] ccp;
        logic signed [42:0]   srp;
        logic signed [CW-1:0] cp;
        logic [15:0]          speed;
        logic                 inv;
        logic                 neg;
    } mid_pay_t;

    // Data carried through the airspeed divider.
    typedef struct packed {
        logic signed [CW-1:0] ccp;
        logic signed [42:0]   srp;
        logic                 inv;
        logic                 neg;
    } late_pay_t;

    // Angle after quadrant reduction.
    typedef struct packed {
        logic signed [CW-1:0] z;
        logic                 flip;
    } red_t;

    // Arc-tangent table in 2^-24 rad.
    function automatic logic signed [CW-1:0] cordic_arc(input int i);
        logic signed [CW-1:0] a;
        case (i)
            0:       a = 27'sd13176795;
            1:       a = 27'sd7778716;
            2:       a = 27'sd4110060;
            3:       a = 27'sd2086331;
            4:       a = 27'sd1047214;
            5:       a = 27'sd524117;
            6:       a = 27'sd262123;
            7:       a = 27'sd131069;
            8:       a = 27'sd65536;
            9:       a = 27'sd32768;
            10:      a = 27'sd16384;
            11:      a = 27'sd8192;
            12:      a = 27'sd4096;
            13:      a = 27'sd2048;
            14:      a = 27'sd1024;
            15:      a = 27'sd512;
            16:      a = 27'sd256;
            17:      a = 27'sd128;
            18:      a = 27'sd64;
            19:      a = 27'sd32;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Fold an angle in 2^-24 rad into [-pi/2, pi/2]; cos is negated when folded.
    function automatic red_t reduce_angle(input logic signed [27:0] a);
        red_t r;
        logic signed [27:0] t;
        t      = a;
        r.flip = 1'b0;
        if (a > PI_HALF_Q24)
        begin
            t      = PI_Q24 - a;
            r.flip = 1'b1;
        end
        else if (a < -PI_HALF_Q24)
        begin
            t      = -PI_Q24 - a;
            r.flip = 1'b1;
        end
        r.z = t[CW-1:0];
        return r;
    endfunction

endpackage

// ===== sv/ctyr_cordic_cell.sv =====
// One CORDIC rotation step with a registered output and a carried payload.
// Depends on ctyr_pkg for the datapath width and the arc-tangent table.
module ctyr_cordic_cell
    import ctyr_pkg::*;
#(
    parameter int STEP = 0,
    parameter int PW   = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 vin,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [CW-1:0] z_in,
    input  logic [PW-1:0]        pay_in,
    output logic                 vout,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic signed [CW-1:0] z_out,
    output logic [PW-1:0]        pay_out
);

    logic signed [CW-1:0] x_next, y_next, z_next;
    logic signed [CW-1:0] x_sh, y_sh;
    logic                 valid_reg;
    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic [PW-1:0]        pay_reg;

    // Rotate toward zero residual angle; shifts are arithmetic floors.
    always_comb
    begin
        x_sh = x_in >>> STEP;
        y_sh = y_in >>> STEP;
        if (!z_in[CW-1])
        begin
            x_next = x_in - y_sh;
            y_next = y_in + x_sh;
            z_next = z_in - cordic_arc(STEP);
        end
        else
        begin
            x_next = x_in + y_sh;
            y_next = y_in - x_sh;
            z_next = z_in + cordic_arc(STEP);
        end
    end

    // Valid bit of this cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= vin;
    end

    // Data registers hand over to the next cell.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            pay_reg <= pay_in;
        end
    end

    assign vout    = valid_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign pay_out = pay_reg;

endmodule

// ===== sv/ctyr_div_cell.sv =====
// One restoring division step: shifts in a dividend bit and produces a quotient bit.
// Depends on ctyr_pkg only through the common import convention.
module ctyr_div_cell
    import ctyr_pkg::*;
#(
    parameter int DW = 16,
    parameter int NW = 20,
    parameter int PW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vin,
    input  logic [DW-1:0] r_in,
    input  logic [NW-1:0] q_in,
    input  logic [DW-1:0] d_in,
    input  logic [PW-1:0] pay_in,
    output logic          vout,
    output logic [DW-1:0] r_out,
    output logic [NW-1:0] q_out,
    output logic [DW-1:0] d_out,
    output logic [PW-1:0] pay_out
);

    logic [DW:0]   trial;
    logic [DW+1:0] diff;
    logic          ge;
    logic [DW-1:0] r_next;
    logic          valid_reg;
    logic [DW-1:0] r_reg, d_reg;
    logic [NW-1:0] q_reg;
    logic [PW-1:0] pay_reg;

    // Partial remainder stays below the divisor, so one compare decides the bit.
    always_comb
    begin
        trial  = {r_in, q_in[NW-1]};
        diff   = {1'b0, trial} - {2'b00, d_in};
        ge     = !diff[DW+1];
        r_next = ge ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= r_next;
            q_reg   <= {q_in[NW-2:0], ge};
            d_reg   <= d_in;
            pay_reg <= pay_in;
        end
    end

    assign vout    = valid_reg;
    assign r_out   = r_reg;
    assign q_out   = q_reg;
    assign d_out   = d_reg;
    assign pay_out = pay_reg;

endmodule

// ===== sv/coordinated_turn_yaw_rate.sv =====
// Coordinated-turn yaw rate: a fully pipelined chain of CORDIC and divider cells.
// Depends on ctyr_pkg, ctyr_cordic_cell and ctyr_div_cell.
//
// A request is taken every cycle unless the chain holds, and passes through:
// 20 CORDIC cells (roll, pitch and clamped roll rotate side by side), 28 cells
// of the tangent divider, two multiply stages, 20 cells of the airspeed
// divider and three output stages. While a finished result waits on out_stall
// the whole chain holds and in_stall is raised; otherwise requests flow in at
// one per clock. The airspeed floor is applied as a request enters and the rate
// limit as its result leaves, so write the configuration only while no request
// is in flight.
module coordinated_turn_yaw_rate
    import ctyr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] roll_angle,
    input  logic signed [14:0] pitch_angle,
    input  logic signed [15:0] pitch_rate,
    input  logic [15:0]        air_speed,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] yaw_body_rate,
    output logic signed [18:0] euler_yaw_rate,
    output logic               inverted_flag
);

    localparam int N   = CORDIC_STEPS;
    localparam int FPW = $bits(front_pay_t);
    localparam int MPW = $bits(mid_pay_t);
    localparam int LPW = $bits(late_pay_t);

    logic        adv;
    logic [14:0] rate_reg;
    logic [15:0] min_speed_reg;

    // Configuration registers with their floors.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= RATE_LIMIT_RESET;
            min_speed_reg <= MIN_AIRSPEED_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RATE_LIMIT:
                    rate_reg <= (cfg_data[14:0] < RATE_LIMIT_LOW) ?
                                RATE_LIMIT_LOW : cfg_data[14:0];
                REG_MIN_AIRSPEED:
                    min_speed_reg <= (cfg_data < MIN_AIRSPEED_LOW) ?
                                     MIN_AIRSPEED_LOW : cfg_data;
                default: ;
            endcase
        end
    end

    // The chain moves whenever the output register is free or being taken.
    logic out_valid_reg;
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // Front end: quadrant reduction, roll clamp, inverted test, airspeed floor.
    logic signed [15:0] roll_c;
    red_t               red_r, red_p, red_c;
    front_pay_t         fp_in;

    always_comb
    begin
        if (roll_angle > ROLL_CLAMP)
            roll_c = ROLL_CLAMP;
        else if (roll_angle < -ROLL_CLAMP)
            roll_c = -ROLL_CLAMP;
        else
            roll_c = roll_angle;
        red_r        = reduce_angle(28'(roll_angle) <<< 11);
        red_p        = reduce_angle(28'(pitch_angle) <<< 11);
        red_c        = reduce_angle(28'(roll_c) <<< 11);
        fp_in.prate  = pitch_rate;
        fp_in.speed  = (air_speed > min_speed_reg) ? air_speed : min_speed_reg;
        fp_in.inv    = (roll_angle >= INVERT_LIMIT) || (roll_angle <= -INVERT_LIMIT);
        fp_in.flip_r = red_r.flip;
    end

    // CORDIC chain: three rotations per cell column.
    logic                 rv [0:N];
    logic signed [CW-1:0] rx [0:N];
    logic signed [CW-1:0] ry [0:N];
    logic signed [CW-1:0] rz [0:N];
    logic [FPW-1:0]       rpay [0:N];
    logic signed [CW-1:0] px [0:N];
    logic signed [CW-1:0] py [0:N];
    logic signed [CW-1:0] pz [0:N];
    logic [0:0]           ppay [0:N];
    logic signed [CW-1:0] cx [0:N];
    logic signed [CW-1:0] cy [0:N];
    logic signed [CW-1:0] cz [0:N];
    logic [0:0]           cpay [0:N];

    assign rv[0]   = in_valid;
    assign rx[0]   = CORDIC_GAIN;
    assign ry[0]   = '0;
    assign rz[0]   = red_r.z;
    assign rpay[0] = fp_in;
    assign px[0]   = CORDIC_GAIN;
    assign py[0]   = '0;
    assign pz[0]   = red_p.z;
    assign ppay[0] = red_p.flip;
    assign cx[0]   = CORDIC_GAIN;
    assign cy[0]   = '0;
    assign cz[0]   = red_c.z;
    assign cpay[0] = red_c.flip;

    for (genvar k = 0; k < N; k++)
    begin : g_cordic
        ctyr_cordic_cell #(.STEP(k), .PW(FPW)) u_roll (
            .clk(clk), .rst_n(rst_n), .en(adv), .vin(rv[k]),
            .x_in(rx[k]), .y_in(ry[k]), .z_in(rz[k]), .pay_in(rpay[k]),
            .vout(rv[k+1]), .x_out(rx[k+1]), .y_out(ry[k+1]), .z_out(rz[k+1]),
            .pay_out(rpay[k+1])
        );
        ctyr_cordic_cell #(.STEP(k), .PW(1)) u_pitch (
            .clk(clk), .rst_n(rst_n), .en(adv), .vin(rv[k]),
            .x_in(px[k]), .y_in(py[k]), .z_in(pz[k]), .pay_in(ppay[k]),
            .vout(), .x_out(px[k+1]), .y_out(py[k+1]), .z_out(pz[k+1]),
            .pay_out(ppay[k+1])
        );
        ctyr_cordic_cell #(.STEP(k), .PW(1)) u_clamp (
            .clk(clk), .rst_n(rst_n), .en(adv), .vin(rv[k]),
            .x_in(cx[k]), .y_in(cy[k]), .z_in(cz[k]), .pay_in(cpay[k]),
            .vout(), .x_out(cx[k+1]), .y_out(cy[k+1]), .z_out(cz[k+1]),
            .pay_out(cpay[k+1])
        );
    end

    // Sine and cosine results, products that do not need the tangent.
    front_pay_t           fo;
    logic signed [CW-1:0] sr, cr, cp, sc, cc;
    logic [CW-1:0]        sc_mag, cc_mag;
    logic signed [53:0]   crcp;
    logic signed [42:0]   srp;
    mid_pay_t             mp_in;

    always_comb
    begin
        fo           = front_pay_t'(rpay[N]);
        sr           = ry[N];
        cr           = fo.flip_r ? -rx[N] : rx[N];
        cp           = ppay[N][0] ? -px[N] : px[N];
        sc           = cy[N];
        cc           = cpay[N][0] ? -cx[N] : cx[N];
        sc_mag       = sc[CW-1] ? CW'(-sc) : CW'(sc);
        cc_mag       = cc[CW-1] ? CW'(-cc) : CW'(cc);
        crcp         = cr * cp;
        srp          = sr * fo.prate;
        mp_in.ccp    = crcp[24+CW-1:24];
        mp_in.srp    = srp;
        mp_in.cp     = cp;
        mp_in.speed  = fo.speed;
        mp_in.inv    = fo.inv;
        mp_in.neg    = sc[CW-1] ^ cc[CW-1];
    end

    // Tangent divider: |sin| * 2^24 / |cos|.
    logic             av [0:DA_NW];
    logic [DA_DW-1:0] ar [0:DA_NW];
    logic [DA_NW-1:0] aq [0:DA_NW];
    logic [DA_DW-1:0] ad [0:DA_NW];
    logic [MPW-1:0]   apay [0:DA_NW];

    assign av[0]   = rv[N];
    assign ar[0]   = sc_mag >> 4;
    assign aq[0]   = {sc_mag[3:0], 24'd0};
    assign ad[0]   = cc_mag;
    assign apay[0] = mp_in;

    for (genvar k = 0; k < DA_NW; k++)
    begin : g_div_tan
        ctyr_div_cell #(.DW(DA_DW), .NW(DA_NW), .PW(MPW)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(adv), .vin(av[k]),
            .r_in(ar[k]), .q_in(aq[k]), .d_in(ad[k]), .pay_in(apay[k]),
            .vout(av[k+1]), .r_out(ar[k+1]), .q_out(aq[k+1]), .d_out(ad[k+1]),
            .pay_out(apay[k+1])
        );
    end

    // Tangent times cos(pitch).
    mid_pay_t             mo;
    logic signed [28:0]   tq;
    logic signed [55:0]   tqcp;
    logic                 vc_reg;
    logic signed [27:0]   tc_reg;
    logic signed [CW-1:0] c_ccp_reg;
    logic signed [42:0]   c_srp_reg;
    logic [15:0]          c_speed_reg;
    logic                 c_inv_reg;

    always_comb
    begin
        mo   = mid_pay_t'(apay[DA_NW]);
        tq   = mo.neg ? -$signed({1'b0, aq[DA_NW]}) : $signed({1'b0, aq[DA_NW]});
        tqcp = tq * mo.cp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else if (adv)
            vc_reg <= av[DA_NW];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tc_reg      <= tqcp[51:24];
            c_ccp_reg   <= mo.ccp;
            c_srp_reg   <= mo.srp;
            c_speed_reg <= mo.speed;
            c_inv_reg   <= mo.inv;
        end
    end

    // Scale by gravity on the magnitude; sign handled after the divide.
    logic [27:0]   tc_mag;
    logic          vd_reg;
    logic [47:0]   prodg_reg;
    logic [15:0]   d_speed_reg;
    late_pay_t     d_pay_reg;

    assign tc_mag = tc_reg[27] ? 28'(-tc_reg) : 28'(tc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= 1'b0;
        else if (adv)
            vd_reg <= vc_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prodg_reg     <= tc_mag * G_Q16;
            d_speed_reg   <= c_speed_reg;
            d_pay_reg.ccp <= c_ccp_reg;
            d_pay_reg.srp <= c_srp_reg;
            d_pay_reg.inv <= c_inv_reg;
            d_pay_reg.neg <= tc_reg[27];
        end
    end

    // Airspeed divider on (|tc| * g) / 2^20.
    logic             bv [0:DB_NW];
    logic [DB_DW-1:0] br [0:DB_NW];
    logic [DB_NW-1:0] bq [0:DB_NW];
    logic [DB_DW-1:0] bd [0:DB_NW];
    logic [LPW-1:0]   bpay [0:DB_NW];

    assign bv[0]   = vd_reg;
    assign br[0]   = DB_DW'(prodg_reg[47:40]);
    assign bq[0]   = prodg_reg[39:20];
    assign bd[0]   = d_speed_reg;
    assign bpay[0] = d_pay_reg;

    for (genvar k = 0; k < DB_NW; k++)
    begin : g_div_speed
        ctyr_div_cell #(.DW(DB_DW), .NW(DB_NW), .PW(LPW)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(adv), .vin(bv[k]),
            .r_in(br[k]), .q_in(bq[k]), .d_in(bd[k]), .pay_in(bpay[k]),
            .vout(bv[k+1]), .r_out(br[k+1]), .q_out(bq[k+1]), .d_out(bd[k+1]),
            .pay_out(bpay[k+1])
        );
    end

    // Euler yaw rate: saturate, apply sign, zero when inverted.
    late_pay_t            lo;
    logic [17:0]          e_mag;
    logic signed [18:0]   euler_next;
    logic                 ve_reg;
    logic signed [18:0]   e_euler_reg;
    logic signed [CW-1:0] e_ccp_reg;
    logic signed [42:0]   e_srp_reg;
    logic                 e_inv_reg;

    always_comb
    begin
        lo    = late_pay_t'(bpay[DB_NW]);
        e_mag = (bq[DB_NW] > 20'(EULER_MAX)) ? EULER_MAX : bq[DB_NW][17:0];
        if (lo.inv)
            euler_next = '0;
        else if (lo.neg)
            euler_next = -$signed({1'b0, e_mag});
        else
            euler_next = $signed({1'b0, e_mag});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ve_reg <= 1'b0;
        else if (adv)
            ve_reg <= bv[DB_NW];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_euler_reg <= euler_next;
            e_ccp_reg   <= lo.ccp;
            e_srp_reg   <= lo.srp;
            e_inv_reg   <= lo.inv;
        end
    end

    // Body-rate accumulator.
    logic signed [45:0] ccpe;
    logic               vf_reg;
    logic signed [46:0] f_acc_reg;
    logic signed [18:0] f_euler_reg;
    logic               f_inv_reg;

    assign ccpe = e_ccp_reg * e_euler_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vf_reg <= 1'b0;
        else if (adv)
            vf_reg <= ve_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_acc_reg   <= 47'(ccpe) - 47'(e_srp_reg);
            f_euler_reg <= e_euler_reg;
            f_inv_reg   <= e_inv_reg;
        end
    end

    // Round half up, clamp to the rate limit, output register.
    logic signed [47:0] rnd;
    logic signed [23:0] body, lim, body_c;
    logic signed [15:0] yaw_reg;
    logic signed [18:0] euler_reg;
    logic               inv_reg;

    always_comb
    begin
        rnd  = 48'(f_acc_reg) + 48'sd8388608;
        body = rnd[47:24];
        lim  = $signed({9'd0, rate_reg});
        if (body > lim)
            body_c = lim;
        else if (body < -lim)
            body_c = -lim;
        else
            body_c = body;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= vf_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            yaw_reg   <= body_c[15:0];
            euler_reg <= f_euler_reg;
            inv_reg   <= f_inv_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign yaw_body_rate  = yaw_reg;
    assign euler_yaw_rate = euler_reg;
    assign inverted_flag  = inv_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for coordinated_turn_yaw_rate: random and directed requests
// with a bit-exact fixed-point predictor. Depends on ctyr_pkg and the block's RTL.
module tb;
    import ctyr_pkg::*;

    localparam longint ANGLE_PI_Q24      = 52707179;
    localparam longint ANGLE_PI_HALF_Q24 = 26353589;
    localparam longint ROT_GAIN_Q24      = 10188014;
    localparam longint GRAVITY_Q16       = 642689;
    localparam longint EULER_SAT         = 262143;
    localparam longint INVERTED_ROLL     = 12868;
    localparam longint TURN_ROLL_CLAMP   = 11436;
    localparam longint RATE_FLOOR        = 41;
    localparam longint SPEED_FLOOR       = 256;
    localparam longint ARC_Q24 [20] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};
    localparam int PIPE_DRAIN = 80;

    typedef struct packed {
        logic signed [15:0] body;
        logic signed [18:0] euler;
        logic               inv;
    } yaw_cmd_t;

    // Predicts yaw commands for accepted requests and checks delivered results in order.
    class yaw_rate_predictor;
        longint   rate_limit;
        longint   min_speed;
        yaw_cmd_t pending_cmds[$];
        int       mismatches;

        function new();
            rate_limit = 3217;
            min_speed  = 2560;
            mismatches = 0;
        endfunction

        function void set_register(logic idx, logic [15:0] data);
            longint v;
            if (idx == REG_RATE_LIMIT)
            begin
                v = data[14:0];
                rate_limit = (v < RATE_FLOOR) ? RATE_FLOOR : v;
            end
            else
            begin
                v = data;
                min_speed = (v < SPEED_FLOOR) ? SPEED_FLOOR : v;
            end
        endfunction

        // Rotation-mode CORDIC after folding the angle into [-pi/2, pi/2].
        function void sin_cos(input longint ang13, output longint s, output longint c);
            longint z, x, y, nx;
            bit     folded;
            z      = ang13 * 2048;
            x      = ROT_GAIN_Q24;
            y      = 0;
            folded = 0;
            if (z > ANGLE_PI_HALF_Q24)
            begin
                z      = ANGLE_PI_Q24 - z;
                folded = 1;
            end
            else if (z < -ANGLE_PI_HALF_Q24)
            begin
                z      = -ANGLE_PI_Q24 - z;
                folded = 1;
            end
            for (int i = 0; i < 20; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - ARC_Q24[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + ARC_Q24[i];
                end
                x = nx;
            end
            s = y;
            c = folded ? -x : x;
        endfunction

        function void note_request(logic signed [15:0] roll, logic signed [14:0] pitch,
                                   logic signed [15:0] prate, logic [15:0] speed);
            longint   r, p, q, v, sr, cr, sp, cp, sc, cc, rc, tq, tc, euler, ccp, body;
            bit       inv;
            yaw_cmd_t cmd;
            r     = roll;
            p     = pitch;
            q     = prate;
            v     = speed;
            v     = (v > min_speed) ? v : min_speed;
            inv   = (r >= INVERTED_ROLL) || (r <= -INVERTED_ROLL);
            euler = 0;
            sin_cos(r, sr, cr);
            sin_cos(p, sp, cp);
            // Coordinated-turn Euler rate only for upright flight.
            if (!inv)
            begin
                rc = r;
                if (rc > TURN_ROLL_CLAMP)
                    rc = TURN_ROLL_CLAMP;
                if (rc < -TURN_ROLL_CLAMP)
                    rc = -TURN_ROLL_CLAMP;
                sin_cos(rc, sc, cc);
                tq    = (cc != 0) ? (sc * 16777216) / cc : 0;
                tc    = (tq * cp) >>> 24;
                euler = (tc * GRAVITY_Q16) / (v * 1048576);
                if (euler > EULER_SAT)
                    euler = EULER_SAT;
                if (euler < -EULER_SAT)
                    euler = -EULER_SAT;
            end
            ccp  = (cr * cp) >>> 24;
            body = (ccp * euler - sr * q + 8388608) >>> 24;
            if (body > rate_limit)
                body = rate_limit;
            if (body < -rate_limit)
                body = -rate_limit;
            cmd.body  = body[15:0];
            cmd.euler = euler[18:0];
            cmd.inv   = inv;
            pending_cmds.push_back(cmd);
        endfunction

        function void check_result(yaw_cmd_t got);
            yaw_cmd_t want;
            if (pending_cmds.size() == 0)
            begin
                $error("unexpected result: yaw_body_rate %0d", got.body);
                mismatches++;
                return;
            end
            want = pending_cmds.pop_front();
            if (got.body !== want.body)
            begin
                $error("yaw_body_rate: expected %0d, got %0d", want.body, got.body);
                mismatches++;
            end
            if (got.euler !== want.euler)
            begin
                $error("euler_yaw_rate: expected %0d, got %0d", want.euler, got.euler);
                mismatches++;
            end
            if (got.inv !== want.inv)
            begin
                $error("inverted_flag: expected %0b, got %0b", want.inv, got.inv);
                mismatches++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic               cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] roll_angle;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] pitch_rate;
    logic [15:0]        air_speed;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] yaw_body_rate;
    logic signed [18:0] euler_yaw_rate;
    logic               inverted_flag;

    yaw_rate_predictor yaw_model;
    bit                send_steady;
    bit                recv_steady;
    int                hold_cycles;

    coordinated_turn_yaw_rate DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .roll_angle     (roll_angle),
        .pitch_angle    (pitch_angle),
        .pitch_rate     (pitch_rate),
        .air_speed      (air_speed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .yaw_body_rate  (yaw_body_rate),
        .euler_yaw_rate (euler_yaw_rate),
        .inverted_flag  (inverted_flag)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one request and hold it until it is accepted.
    task automatic send_request(logic signed [15:0] roll, logic signed [14:0] pitch,
                                logic signed [15:0] prate, logic [15:0] speed);
        int gap;
        gap = send_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        roll_angle  <= roll;
        pitch_angle <= pitch;
        pitch_rate  <= prate;
        air_speed   <= speed;
        do
            @(posedge clk);
        while (in_stall);
        yaw_model.note_request(roll, pitch, prate, speed);
    endtask

    // Random request biased toward the roll thresholds and the airspeed floor.
    task automatic send_random();
        logic signed [15:0] roll;
        logic [15:0]        speed;
        int                 pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            roll = 16'($urandom());
        else if (pick < 8)
            roll = 16'($signed(16'($urandom_range(0, 25736)))
                       * ($urandom_range(0, 1) ? 1 : -1));
        else
            roll = 16'((($urandom_range(0, 1)) ? INVERTED_ROLL : TURN_ROLL_CLAMP)
                       + $signed($urandom_range(0, 4)) - 2);
        if ($urandom_range(0, 1))
            roll = -roll;
        speed = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3000)) : 16'($urandom());
        send_request(roll, 15'($urandom()), 16'($urandom()), speed);
    endtask

    // Register writes happen only with the pipeline empty.
    task automatic write_register(logic idx, logic [15:0] data);
        in_valid <= 1'b0;
        while (yaw_model.pending_cmds.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        yaw_model.set_register(idx, data);
    endtask

    // Result side: check accepted results, then choose the next stall value.
    initial
    begin : result_side
        int       run_left;
        bit       stalling;
        yaw_cmd_t got;
        run_left  = 0;
        stalling  = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.body  = yaw_body_rate;
                got.euler = euler_yaw_rate;
                got.inv   = inverted_flag;
                yaw_model.check_result(got);
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                stalling = 1;
                run_left = 0;
            end
            else if (recv_steady)
                stalling = 0;
            else if (run_left > 0)
                run_left--;
            else
            begin
                stalling = ($urandom_range(0, 99) < 35);
                run_left = stalling ? pick_gap() : $urandom_range(0, 8);
            end
            out_stall <= stalling;
        end
    end

    initial
    begin : watchdog
        #20ms;
        $display("coordinated_turn_yaw_rate regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        yaw_model   = new();
        send_steady = 0;
        recv_steady = 0;
        hold_cycles = 0;
        rst_n       <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_index   <= REG_RATE_LIMIT;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        roll_angle  <= '0;
        pitch_angle <= '0;
        pitch_rate  <= '0;
        air_speed   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: level flight, threshold rolls, rolls past pi, field extremes.
        send_request(0, 0, 0, 0);
        send_request(25736, 12868, 32767, 65535);
        send_request(-25736, -12868, -32767, 0);
        send_request(12868, 0, 1000, 2560);
        send_request(-12868, 0, -1000, 2560);
        send_request(12867, 100, 32767, 256);
        send_request(-12867, -100, -32768, 256);
        send_request(11436, 0, 0, 255);
        send_request(11437, 0, 0, 1);
        send_request(-11437, 0, 0, 2561);
        send_request(32767, 16383, -32768, 65535);
        send_request(-32768, -16384, 32767, 0);
        send_request(-1, -1, -1, 16'hffff);
        send_request(5000, 12868, 2000, 512);
        send_request(-5000, -12868, -2000, 40000);
        send_request(11436, 0, 32767, 0);
        send_request(-11436, 0, -32767, 0);

        // Floors: writes below the low bounds clamp to them.
        write_register(REG_RATE_LIMIT, 16'd0);
        write_register(REG_MIN_AIRSPEED, 16'd0);
        for (int i = 0; i < 240; i++)
            send_random();

        // Upper extremes; bit 15 of the rate write is dropped.
        write_register(REG_RATE_LIMIT, 16'hffff);
        write_register(REG_MIN_AIRSPEED, 16'hffff);
        for (int i = 0; i < 240; i++)
            send_random();

        // Back to nominal values, with the result side held off for a long time.
        write_register(REG_RATE_LIMIT, 16'd3217);
        write_register(REG_MIN_AIRSPEED, 16'd2560);
        send_steady = 1;
        hold_cycles = 300;
        for (int i = 0; i < 240; i++)
            send_random();
        send_steady = 0;

        // Back-to-back flow with no idling on either side.
        write_register(REG_RATE_LIMIT, 16'd41);
        write_register(REG_MIN_AIRSPEED, 16'd256);
        send_steady = 1;
        recv_steady = 1;
        for (int i = 0; i < 240; i++)
            send_random();
        send_steady = 0;
        recv_steady = 0;

        // Random settings.
        for (int phase = 0; phase < 2; phase++)
        begin
            write_register(REG_RATE_LIMIT, 16'($urandom()));
            write_register(REG_MIN_AIRSPEED, 16'($urandom_range(200, 8000)));
            for (int i = 0; i < 240; i++)
                send_random();
        end

        in_valid <= 1'b0;
        while (yaw_model.pending_cmds.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
        if (yaw_model.mismatches == 0 && yaw_model.pending_cmds.size() == 0)
            $display("coordinated_turn_yaw_rate regression: pass");
        else
            $display("coordinated_turn_yaw_rate regression: fail");
        $finish;
    end
endmodule
